FILE: rtl/imad_pkg.sv
// ----------------------------------------------------------------------------
// imad_pkg: shared types, tables and helpers for the IMA ADPCM decoder
// Holds the step table, the index adjust table and the item formats that
// travel between the front end, the command queue and the decode engine.
// ----------------------------------------------------------------------------
package imad_pkg;

  // Input item kinds
  typedef enum logic [0:0] {
    KindHeader = 1'b0,
    KindCode   = 1'b1
  } kind_e;

  // Highest legal step index
  localparam logic [6:0] MaxIndex = 7'd88;
  localparam int unsigned NumSteps = 89;

  // Saturation bounds on the widened predictor sum
  localparam logic signed [17:0] PcmMax = 18'sd32767;
  localparam logic signed [17:0] PcmMin = -18'sd32768;

  // Step size for each index
  localparam logic [14:0] StepTable [NumSteps] = '{
    15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,    15'd13,
    15'd14,    15'd16,    15'd17,    15'd19,    15'd21,    15'd23,    15'd25,
    15'd28,    15'd31,    15'd34,    15'd37,    15'd41,    15'd45,    15'd50,
    15'd55,    15'd60,    15'd66,    15'd73,    15'd80,    15'd88,    15'd97,
    15'd107,   15'd118,   15'd130,   15'd143,   15'd157,   15'd173,   15'd190,
    15'd209,   15'd230,   15'd253,   15'd279,   15'd307,   15'd337,   15'd371,
    15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,   15'd724,
    15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,  15'd1411,
    15'd1552,  15'd1707,  15'd1878,  15'd2066,  15'd2272,  15'd2499,  15'd2749,
    15'd3024,  15'd3327,  15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,
    15'd5894,  15'd6484,  15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442,
    15'd11487, 15'd12635, 15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350,
    15'd22385, 15'd24623, 15'd27086, 15'd29794, 15'd32767
  };

  // Command passed from the front end to the decode engine
  typedef struct packed {
    logic               is_hdr;
    logic signed [15:0] hdr_pred;
    logic [6:0]         hdr_idx;
    logic [3:0]         nibble;
    logic               last;
  } cmd_t;

  // Result item
  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
  } out_t;

  // Look up the step for an index; indexes past the top read the top entry
  function automatic logic [14:0] step_of(input logic [6:0] idx);
    logic [14:0] res;
    if (idx > MaxIndex) begin
      res = StepTable[MaxIndex];
    end else begin
      res = StepTable[idx];
    end
    return res;
  endfunction

  // Index change for the magnitude bits of a code
  function automatic logic signed [7:0] idx_adjust(input logic [2:0] mag);
    logic signed [7:0] res;
    case (mag)
      3'd4:    res = 8'sd2;
      3'd5:    res = 8'sd4;
      3'd6:    res = 8'sd6;
      3'd7:    res = 8'sd8;
      default: res = -8'sd1;
    endcase
    return res;
  endfunction

endpackage

FILE: rtl/imad_fifo.sv
// ----------------------------------------------------------------------------
// imad_fifo: small synchronous queue
// Register-based FIFO with push/full and pop/empty; the head entry is shown
// on the read port while the queue is not empty.
// ----------------------------------------------------------------------------
module imad_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  // Advance pointers with wrap at the depth
  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // Store pushed entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

FILE: rtl/imad_front.sv
// ----------------------------------------------------------------------------
// imad_front: input front end
// Accepts input items, clamps header indexes and splits each code byte
// into one or two nibble commands for the decode engine.
// ----------------------------------------------------------------------------
module imad_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic               kind_i,
  input  logic signed [15:0] header_predictor_i,
  input  logic [7:0]         header_index_i,
  input  logic [7:0]         code_byte_i,
  input  logic               single_sample_i,
  output logic               cmd_push_o,
  output imad_pkg::cmd_t     cmd_data_o,
  input  logic               cmd_full_i
);

  logic       hold_valid_q, hold_valid_d;
  logic [3:0] hold_nib_q;
  logic       accept;
  logic       is_code;
  logic [6:0] idx_clamped;

  // Stall while the high nibble waits or the queue has no room
  assign full    = hold_valid_q || cmd_full_i;
  assign accept  = push && !full;
  assign is_code = (imad_pkg::kind_e'(kind_i) == imad_pkg::KindCode);

  // Clamp the header index to the table range
  assign idx_clamped = (header_index_i > 8'(imad_pkg::MaxIndex)) ?
                       imad_pkg::MaxIndex : header_index_i[6:0];

  // Build the command for this cycle: a held high nibble goes first
  always_comb begin
    cmd_push_o          = hold_valid_q || accept;
    cmd_data_o          = '0;
    cmd_data_o.hdr_pred = header_predictor_i;
    cmd_data_o.hdr_idx  = idx_clamped;
    if (hold_valid_q) begin
      cmd_data_o.is_hdr = 1'b0;
      cmd_data_o.nibble = hold_nib_q;
      cmd_data_o.last   = 1'b1;
    end else begin
      cmd_data_o.is_hdr = !is_code;
      cmd_data_o.nibble = code_byte_i[3:0];
      cmd_data_o.last   = single_sample_i;
    end
  end

  // Hold the high nibble of a two-sample byte until the command queue takes it
  always_comb begin
    hold_valid_d = hold_valid_q;
    if (hold_valid_q && !cmd_full_i) begin
      hold_valid_d = 1'b0;
    end else if (accept && is_code && !single_sample_i) begin
      hold_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hold_nib_q <= code_byte_i[7:4];
    end
  end

endmodule

FILE: rtl/imad_engine.sv
// ----------------------------------------------------------------------------
// imad_engine: nibble decode engine
// One command a cycle unless stalled: header loads set the predictor and index,
// nibbles update the predictor with saturation and move the step index.
// ----------------------------------------------------------------------------
module imad_engine (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_empty_i,
  input  imad_pkg::cmd_t cmd_data_i,
  output logic           cmd_pop_o,
  input  logic           out_full_i,
  output logic           out_push_o,
  output imad_pkg::out_t out_data_o
);

  logic signed [15:0] pred_q, pred_d;
  logic [6:0]         idx_q, idx_d;
  logic [14:0]        step_q, step_d;
  logic               fire;
  logic [15:0]        diff;
  logic signed [17:0] sum;
  logic signed [17:0] pred_ext, diff_ext;
  logic signed [7:0]  idx_sum;
  logic signed [15:0] pred_sat;
  logic [6:0]         idx_next;

  // Headers need no result slot; nibbles wait for room
  assign fire       = !cmd_empty_i && (cmd_data_i.is_hdr || !out_full_i);
  assign cmd_pop_o  = fire;
  assign out_push_o = fire && !cmd_data_i.is_hdr;

  // Sum the shifted partial steps selected by the magnitude bits
  always_comb begin
    diff = 16'(step_q >> 3);
    if (cmd_data_i.nibble[2]) diff = diff + 16'(step_q);
    if (cmd_data_i.nibble[1]) diff = diff + 16'(step_q >> 1);
    if (cmd_data_i.nibble[0]) diff = diff + 16'(step_q >> 2);
  end

  // Add or subtract, then saturate to 16 bits
  assign pred_ext = 18'(pred_q);
  assign diff_ext = signed'({2'b00, diff});
  assign sum      = cmd_data_i.nibble[3] ? (pred_ext - diff_ext) : (pred_ext + diff_ext);

  always_comb begin
    if (sum > imad_pkg::PcmMax) begin
      pred_sat = 16'sh7fff;
    end else if (sum < imad_pkg::PcmMin) begin
      pred_sat = -16'sh8000;
    end else begin
      pred_sat = sum[15:0];
    end
  end

  // Move the index and clamp it to the table range
  assign idx_sum = signed'({1'b0, idx_q}) + imad_pkg::idx_adjust(cmd_data_i.nibble[2:0]);

  always_comb begin
    if (idx_sum < 8'sd0) begin
      idx_next = '0;
    end else if (idx_sum > signed'({1'b0, imad_pkg::MaxIndex})) begin
      idx_next = imad_pkg::MaxIndex;
    end else begin
      idx_next = idx_sum[6:0];
    end
  end

  // Select next state; the step for the next index is looked up ahead
  always_comb begin
    pred_d = pred_q;
    idx_d  = idx_q;
    step_d = step_q;
    if (fire) begin
      if (cmd_data_i.is_hdr) begin
        pred_d = cmd_data_i.hdr_pred;
        idx_d  = cmd_data_i.hdr_idx;
      end else begin
        pred_d = pred_sat;
        idx_d  = idx_next;
      end
      step_d = imad_pkg::step_of(idx_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pred_q <= '0;
      idx_q  <= '0;
      step_q <= imad_pkg::StepTable[0];
    end else begin
      pred_q <= pred_d;
      idx_q  <= idx_d;
      step_q <= step_d;
    end
  end

  assign out_data_o.sample = pred_sat;
  assign out_data_o.last   = cmd_data_i.last;

  // Index never leaves the table range
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= imad_pkg::MaxIndex)
    else $error("step index out of range");

  // Cached step always matches the current index
  a_step_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q == imad_pkg::step_of(idx_q))
    else $error("cached step does not match index");

  // A header load leaves exactly the header values behind
  a_hdr_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && cmd_data_i.is_hdr) |=>
      (pred_q == $past(cmd_data_i.hdr_pred) && idx_q == $past(cmd_data_i.hdr_idx)))
    else $error("header load not applied");

endmodule

FILE: rtl/ima_adpcm_nibble_decoder.sv
// ----------------------------------------------------------------------------
// ima_adpcm_nibble_decoder: 4-bit IMA ADPCM to 16-bit PCM decoder
// Top level: front end, command queue, decode engine and result queue.
// ----------------------------------------------------------------------------
// A header item loads the predictor and step index (index clamped to 88) and
// yields no sample. A code byte yields two samples, low nibble first, or just
// the low-nibble sample when single_sample is set; last marks the final
// sample of each byte. The front end turns each byte into one nibble command
// per cycle while the command queue has room: a two-sample byte holds off new
// input until its high nibble is queued, a header or single-sample byte does
// not. The engine retires one command per cycle, nibbles only while the result
// queue has room, and that queue lets the block keep taking items while results
// wait to be popped. Each command, then its sample, is registered in a queue.
module ima_adpcm_nibble_decoder #(
  parameter int unsigned CmdDepth = 2,
  parameter int unsigned OutDepth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic               kind_i,
  input  logic signed [15:0] header_predictor_i,
  input  logic [7:0]         header_index_i,
  input  logic [7:0]         code_byte_i,
  input  logic               single_sample_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] sample_o,
  output logic               last_o
);

  localparam int unsigned CmdW = $bits(imad_pkg::cmd_t);
  localparam int unsigned OutW = $bits(imad_pkg::out_t);

  logic           cmd_push, cmd_full, cmd_pop, cmd_empty;
  imad_pkg::cmd_t cmd_wdata, cmd_rdata;
  logic           out_push, out_full;
  imad_pkg::out_t out_wdata, out_rdata;

  // Accept and split input items
  imad_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push               (push),
    .full               (full),
    .kind_i             (kind_i),
    .header_predictor_i (header_predictor_i),
    .header_index_i     (header_index_i),
    .code_byte_i        (code_byte_i),
    .single_sample_i    (single_sample_i),
    .cmd_push_o         (cmd_push),
    .cmd_data_o         (cmd_wdata),
    .cmd_full_i         (cmd_full)
  );

  // Decouple front end from the engine
  imad_fifo #(
    .Width (CmdW),
    .Depth (CmdDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_wdata),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_rdata),
    .empty_o (cmd_empty)
  );

  // Decode one nibble command per cycle while the result queue has room
  imad_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_data_i  (cmd_rdata),
    .cmd_pop_o   (cmd_pop),
    .out_full_i  (out_full),
    .out_push_o  (out_push),
    .out_data_o  (out_wdata)
  );

  // Hold results until popped
  imad_fifo #(
    .Width (OutW),
    .Depth (OutDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .wdata_i (out_wdata),
    .full_o  (out_full),
    .pop_i   (pop),
    .rdata_o (out_rdata),
    .empty_o (empty)
  );

  assign sample_o = out_rdata.sample;
  assign last_o   = out_rdata.last;

endmodule

FILE: sim/imad_checker.sv
// ----------------------------------------------------------------------------
// imad_checker: sample predictor and scoreboard for the IMA ADPCM decoder
// Watches both queue channels of the decoder. Each accepted input item runs
// through a local copy of the decoder state to produce the expected samples;
// each popped sample is compared with the oldest expected one.
// ----------------------------------------------------------------------------
module imad_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic               full_i,
  input  logic               kind_i,
  input  logic signed [15:0] header_predictor_i,
  input  logic [7:0]         header_index_i,
  input  logic [7:0]         code_byte_i,
  input  logic               single_sample_i,
  input  logic               empty_i,
  input  logic               pop_i,
  input  logic signed [15:0] sample_i,
  input  logic               last_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 checked_o
);

  // Local decoder state
  logic signed [15:0] pcm_q;
  logic [6:0]         index_q;

  // Samples predicted but not yet popped, oldest first
  imad_pkg::out_t pcm_expect_q[$];
  imad_pkg::out_t oldest;

  int fail_count = 0;
  int pending    = 0;
  int checked    = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = pending;
  assign checked_o    = checked;

  // Print one line per mismatch up to the fiftieth; keep the log short on a badly broken block
  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= 50) begin
      $display("[%0t] MISMATCH: %s", $time, msg);
    end
  endtask

  // Decode one nibble against the local state and queue the expected sample
  task automatic advance_decoder(input logic [3:0] code, input logic is_last);
    int             step;
    int             delta;
    int             acc;
    int             idx;
    imad_pkg::out_t res;
    step  = int'(imad_pkg::StepTable[index_q]);
    delta = step >> 3;
    if (code[2]) delta += step;
    if (code[1]) delta += step >> 1;
    if (code[0]) delta += step >> 2;
    acc = code[3] ? int'(pcm_q) - delta : int'(pcm_q) + delta;
    if (acc > 32767) begin
      acc = 32767;
    end else if (acc < -32768) begin
      acc = -32768;
    end
    pcm_q = 16'(acc);
    // Small magnitudes step the index down by one, large ones up by 2..8
    idx = int'(index_q) + (code[2] ? 2 * (int'(code[1:0]) + 1) : -1);
    if (idx < 0) begin
      idx = 0;
    end else if (idx > int'(imad_pkg::MaxIndex)) begin
      idx = int'(imad_pkg::MaxIndex);
    end
    index_q    = 7'(idx);
    res.sample = pcm_q;
    res.last   = is_last;
    pcm_expect_q.push_back(res);
  endtask

  // Predict on accepted items, compare on popped samples
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcm_q   = '0;
      index_q = '0;
      pcm_expect_q.delete();
    end else begin
      if (push_i && !full_i) begin
        if (kind_i == imad_pkg::KindHeader) begin
          pcm_q   = header_predictor_i;
          index_q = (header_index_i > 8'(imad_pkg::MaxIndex)) ?
                    imad_pkg::MaxIndex : header_index_i[6:0];
        end else begin
          advance_decoder(code_byte_i[3:0], single_sample_i);
          if (!single_sample_i) begin
            advance_decoder(code_byte_i[7:4], 1'b1);
          end
        end
      end
      if (pop_i && !empty_i) begin
        if (pcm_expect_q.size() == 0) begin
          report_mismatch($sformatf("unexpected sample %0d last %0b", sample_i, last_i));
        end else begin
          oldest = pcm_expect_q.pop_front();
          checked++;
          if (sample_i !== oldest.sample) begin
            report_mismatch($sformatf("sample %0d, expected %0d (last %0b)",
                                      sample_i, oldest.sample, oldest.last));
          end
          if (last_i !== oldest.last) begin
            report_mismatch($sformatf("last %0b, expected %0b (sample %0d)",
                                      last_i, oldest.last, oldest.sample));
          end
        end
      end
    end
    pending = pcm_expect_q.size();
  end

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the IMA ADPCM nibble decoder
// Drives header and code-byte items through the input queue under several
// idle and stall mixes, pops samples at random, and leaves all checking to
// the scoreboard beside the block. Gives the verdict at the end.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int IdleLimit   = 2000;
  localparam int ItemsPerMix = 320;
  localparam int TailCycles  = 10;

  logic               clk_i            = 1'b0;
  logic               rst_ni           = 1'b0;
  logic               push             = 1'b0;
  logic               kind             = imad_pkg::KindHeader;
  logic signed [15:0] header_predictor = '0;
  logic [7:0]         header_index     = '0;
  logic [7:0]         code_byte        = '0;
  logic               single_sample    = 1'b0;
  logic               pop              = 1'b0;
  logic               full;
  logic               empty;
  logic signed [15:0] sample;
  logic               last;

  int send_idle_pct = 0;
  int pop_stall_pct = 0;
  int items_sent    = 0;
  int headers_sent  = 0;
  int singles_sent  = 0;
  int idle_cycles   = 0;
  int fail_count;
  int pending;
  int checked;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  ima_adpcm_nibble_decoder dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push               (push),
    .full               (full),
    .kind_i             (kind),
    .header_predictor_i (header_predictor),
    .header_index_i     (header_index),
    .code_byte_i        (code_byte),
    .single_sample_i    (single_sample),
    .empty              (empty),
    .pop                (pop),
    .sample_o           (sample),
    .last_o             (last)
  );

  imad_checker sample_check (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push_i             (push),
    .full_i             (full),
    .kind_i             (kind),
    .header_predictor_i (header_predictor),
    .header_index_i     (header_index),
    .code_byte_i        (code_byte),
    .single_sample_i    (single_sample),
    .empty_i            (empty),
    .pop_i              (pop),
    .sample_i           (sample),
    .last_i             (last),
    .fail_count_o       (fail_count),
    .pending_o          (pending),
    .checked_o          (checked)
  );

  // Pop at random according to the current stall rate
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  // End the run when no item moves on either side for too long
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Watchdog: no item moved for %0d cycles, %0d samples outstanding",
               IdleLimit, pending);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one item, idling first at random, and hold it until taken
  task automatic send_item(input imad_pkg::kind_e k, input logic signed [15:0] hp,
                           input logic [7:0] hi, input logic [7:0] cb, input logic ss);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push             <= 1'b1;
    kind             <= k;
    header_predictor <= hp;
    header_index     <= hi;
    code_byte        <= cb;
    single_sample    <= ss;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    items_sent++;
    if (k == imad_pkg::KindHeader) begin
      headers_sent++;
    end else if (ss) begin
      singles_sent++;
    end
  endtask

  // Header with random noise on the code-byte fields
  task automatic send_header(input logic signed [15:0] hp, input logic [7:0] hi);
    send_item(imad_pkg::KindHeader, hp, hi, 8'($urandom), 1'($urandom_range(1)));
  endtask

  // Code byte with random noise on the header fields
  task automatic send_code(input logic [7:0] cb, input logic ss);
    send_item(imad_pkg::KindCode, 16'($urandom), 8'($urandom), cb, ss);
  endtask

  // Hold off the sender until every expected sample has been popped
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // One packet: usually a header, then a run of code bytes, sometimes ending odd
  task automatic send_packet();
    int                 n;
    int                 bias;
    logic signed [15:0] hp;
    logic [7:0]         hi;
    logic [7:0]         cb;
    logic               ss;
    case ($urandom_range(9))
      0:       hp = 16'sh7fff;
      1:       hp = 16'sh8000;
      default: hp = 16'($urandom);
    endcase
    hi = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(88));
    // Skip the header now and then so the state carries across packets
    if ($urandom_range(7) != 0) begin
      send_header(hp, hi);
    end
    n    = $urandom_range(30, 4);
    bias = $urandom_range(5);
    for (int i = 0; i < n; i++) begin
      cb = 8'($urandom);
      // Same-sign runs push the predictor into saturation
      if (bias == 0) begin
        cb = cb & 8'h77;
      end else if (bias == 1) begin
        cb = cb | 8'h88;
      end
      ss = (i == n - 1) ? ($urandom_range(2) == 0) : ($urandom_range(19) == 0);
      send_code(cb, ss);
    end
  endtask

  initial begin
    int target;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: index clamp, saturation both ways, index floor, every nibble
    send_header(16'sh7fff, 8'd255);
    send_code(8'h77, 1'b0);
    send_code(8'h07, 1'b1);
    send_header(16'sh8000, 8'd88);
    send_code(8'hff, 1'b0);
    send_header(16'sh0000, 8'd0);
    send_code(8'h00, 1'b0);
    send_code(8'h88, 1'b0);
    send_header(16'sd1234, 8'd89);
    send_header(-16'sd1, 8'd87);
    for (int i = 0; i < 8; i++) begin
      send_code({4'(2 * i + 1), 4'(2 * i)}, 1'b0);
    end
    send_code(8'hf3, 1'b1);
    send_header(16'sh4000, 8'h80);
    send_code(8'h5a, 1'b1);
    send_code(8'ha5, 1'b0);
    wait_drained();

    // Random packets under each handshake mix
    for (int mix = 0; mix < 4; mix++) begin
      case (mix)
        0:       begin send_idle_pct = 0;  pop_stall_pct = 0;  end
        1:       begin send_idle_pct = 65; pop_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  pop_stall_pct = 65; end
        default: begin send_idle_pct = 24; pop_stall_pct = 24; end
      endcase
      target = items_sent + ItemsPerMix;
      while (items_sent < target) begin
        send_packet();
      end
      wait_drained();
    end

    // Let any trailing work settle, then give the verdict
    repeat (TailCycles) @(posedge clk_i);
    $display("Sent %0d items (%0d headers, %0d single-sample bytes); %0d samples checked",
             items_sent, headers_sent, singles_sent, checked);
    $display("Mixes run: free flow, sender idling, receiver stalling, both idling");
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/imad_pkg.sv
rtl/imad_fifo.sv
rtl/imad_front.sv
rtl/imad_engine.sv
rtl/ima_adpcm_nibble_decoder.sv
sim/imad_checker.sv
sim/tb_top.sv
